// ===== design/acu_pkg.sv =====
package acu_pkg;

	// Fixed field widths of the stream items.
	localparam int KIND_W   = 2;
	localparam int OPC_W    = 5;
	localparam int ADDR_W   = 6;
	localparam int FIELD_W  = 32;

	// Width of the epoch tag kept beside every memory word.
	localparam int EPOCH_W  = 8;

	// Word value that marks an empty memory location after reset.
	localparam logic signed [FIELD_W-1:0] EMPTY_WORD = -32'sd9999;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_EXEC  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	// Instruction opcodes.
	localparam logic [OPC_W-1:0] OP_LDA  = 5'd0;
	localparam logic [OPC_W-1:0] OP_ADD  = 5'd1;
	localparam logic [OPC_W-1:0] OP_MUL  = 5'd2;
	localparam logic [OPC_W-1:0] OP_SUB  = 5'd3;
	localparam logic [OPC_W-1:0] OP_INC  = 5'd4;
	localparam logic [OPC_W-1:0] OP_DEC  = 5'd5;
	localparam logic [OPC_W-1:0] OP_EXC  = 5'd6;
	localparam logic [OPC_W-1:0] OP_OR   = 5'd7;
	localparam logic [OPC_W-1:0] OP_NOT  = 5'd8;
	localparam logic [OPC_W-1:0] OP_AND  = 5'd9;
	localparam logic [OPC_W-1:0] OP_XOR  = 5'd10;
	localparam logic [OPC_W-1:0] OP_XNOR = 5'd11;
	localparam logic [OPC_W-1:0] OP_NOR  = 5'd12;
	localparam logic [OPC_W-1:0] OP_NAND = 5'd13;
	localparam logic [OPC_W-1:0] OP_CLA  = 5'd14;
	localparam logic [OPC_W-1:0] OP_CMA  = 5'd15;
	localparam logic [OPC_W-1:0] OP_TCA  = 5'd16;
	localparam logic [OPC_W-1:0] OP_CIR  = 5'd17;
	localparam logic [OPC_W-1:0] OP_GTR  = 5'd18;
	localparam logic [OPC_W-1:0] OP_LES  = 5'd19;
	localparam logic [OPC_W-1:0] OP_SHL  = 5'd20;
	localparam logic [OPC_W-1:0] OP_SHR  = 5'd21;

	// Memory side effects requested by the execute logic.
	typedef struct packed {
		logic mem_we;
		logic clr;
	} alu_ctrl_t;

	// Memory status seen by the stream control.
	typedef struct packed {
		logic busy;
		logic epoch_full;
	} mem_stat_t;

endpackage

// ===== design/acu_mem.sv =====
module acu_mem #(
	parameter int MEM_DEPTH  = 64,
	parameter int DATA_WIDTH = 32,
	parameter int AW         = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic [DATA_WIDTH-1:0] rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [DATA_WIDTH-1:0] wr_data,
	input  logic                  clr,
	output acu_pkg::mem_stat_t    stat
);
	import acu_pkg::*;

	localparam int EW = DATA_WIDTH + EPOCH_W;
	localparam logic [DATA_WIDTH-1:0] EMPTY = DATA_WIDTH'(EMPTY_WORD);
	localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

	logic [EW-1:0]      mem_array [MEM_DEPTH];
	logic [EW-1:0]      rd_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               sweep_q;
	logic               fill_empty_q;
	logic [AW-1:0]      sweep_cnt_q;

	// A word whose tag is not the current epoch has been cleared since it was
	// written. The sweeps keep every tag equal to zero when the epoch wraps.
	always_ff @(posedge clk) begin
		if (sweep_q) begin
			mem_array[sweep_cnt_q] <= {EPOCH_W'(0), fill_empty_q ? EMPTY : '0};
		end else if (wr_en) begin
			mem_array[wr_addr] <= {epoch_q, wr_data};
		end
		if (rd_en) begin
			rd_q <= mem_array[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q      <= '0;
			sweep_q      <= 1'b1;
			fill_empty_q <= 1'b1;
			sweep_cnt_q  <= '0;
		end else begin
			if (sweep_q) begin
				if (sweep_cnt_q == LAST_ADDR) begin
					sweep_q     <= 1'b0;
					sweep_cnt_q <= '0;
				end else begin
					sweep_cnt_q <= sweep_cnt_q + AW'(1);
				end
			end
			if (clr) begin
				if (epoch_q == EPOCH_MAX) begin
					epoch_q      <= '0;
					sweep_q      <= 1'b1;
					fill_empty_q <= 1'b0;
				end else begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
			end
		end
	end

	assign rd_data = (rd_q[EW-1:DATA_WIDTH] == epoch_q) ? rd_q[DATA_WIDTH-1:0] : '0;
	assign stat.busy       = sweep_q;
	assign stat.epoch_full = (epoch_q == EPOCH_MAX);

endmodule

// ===== design/acu_alu.sv =====
module acu_alu #(
	parameter int DATA_WIDTH = 32
) (
	input  logic [acu_pkg::KIND_W-1:0] kind,
	input  logic [acu_pkg::OPC_W-1:0]  opcode,
	input  logic [DATA_WIDTH-1:0]      wv,
	input  logic [DATA_WIDTH-1:0]      ac,
	input  logic [DATA_WIDTH-1:0]      tr,
	input  logic [DATA_WIDTH-1:0]      m,
	output logic [DATA_WIDTH-1:0]      acc_next,
	output logic [DATA_WIDTH-1:0]      tr_next,
	output logic [DATA_WIDTH-1:0]      mem_wdata,
	output logic [DATA_WIDTH-1:0]      word_after,
	output acu_pkg::alu_ctrl_t         ctrl
);
	import acu_pkg::*;

	logic [DATA_WIDTH-1:0] logic_res;
	logic                  is_logic;
	logic                  ac_lt_m;
	logic                  m_lt_ac;

	assign ac_lt_m = $signed(ac) < $signed(m);
	assign m_lt_ac = $signed(m) < $signed(ac);

	// The logic ops also leave their result in the temporary register.
	always_comb begin
		logic_res = '0;
		is_logic  = 1'b1;
		unique case (opcode)
			OP_OR:   logic_res = ac | m;
			OP_NOT:  logic_res = ~m;
			OP_AND:  logic_res = ac & m;
			OP_XOR:  logic_res = ac ^ m;
			OP_XNOR: logic_res = ~(ac ^ m);
			OP_NOR:  logic_res = ~(ac | m);
			OP_NAND: logic_res = ~(ac & m);
			default: is_logic  = 1'b0;
		endcase
	end

	always_comb begin
		acc_next   = ac;
		tr_next    = tr;
		mem_wdata  = wv;
		word_after = m;
		ctrl       = '0;
		unique case (kind)
			KIND_WRITE: begin
				ctrl.mem_we = 1'b1;
				word_after  = wv;
			end
			KIND_CLEAR: begin
				ctrl.clr   = 1'b1;
				word_after = '0;
			end
			KIND_EXEC: begin
				if (is_logic) begin
					acc_next = logic_res;
					tr_next  = logic_res;
				end else begin
					unique case (opcode)
						OP_LDA: acc_next = m;
						OP_ADD: acc_next = ac + m;
						OP_MUL: acc_next = DATA_WIDTH'(ac * m);
						OP_SUB: acc_next = ac - m;
						OP_INC: acc_next = ac + DATA_WIDTH'(1);
						OP_DEC: acc_next = ac - DATA_WIDTH'(1);
						OP_EXC: begin
							tr_next     = ac;
							acc_next    = m;
							ctrl.mem_we = 1'b1;
							mem_wdata   = ac;
							word_after  = ac;
						end
						OP_CLA: acc_next = '0;
						OP_CMA: acc_next = ~ac;
						OP_TCA: acc_next = -ac;
						OP_CIR: acc_next = ac;
						OP_GTR: acc_next = ac_lt_m ? m : ac;
						OP_LES: acc_next = m_lt_ac ? m : ac;
						OP_SHL: acc_next = {ac[DATA_WIDTH-2:0], 1'b0};
						OP_SHR: acc_next = {ac[DATA_WIDTH-1], ac[DATA_WIDTH-1:1]};
						default: acc_next = ac;
					endcase
				end
			end
			default: acc_next = ac;
		endcase
	end

endmodule

// ===== design/accumulator_cpu_execute_unit.sv =====
// Channel | Direction | Beat contents
// s_*     | in        | tuser: kind; tdata: opcode, mem_address, write_value
// m_*     | out       | tdata: acc_value, temp_value, mem_word
//
// One instruction per cycle while no output stall or memory sweep holds the flow:
// the memory is read into a register as a beat is taken, and the execute logic plus
// the state update run on that word in the execute stage. After reset the memory is
// swept to the empty marker, one word a cycle, with s_tready low. A memory clear only
// steps the epoch tag, except every 256th, which starts a zeroing sweep with s_tready low.
// A stalled output holds its beat; a new beat is still taken while it waits
// as long as the execute stage is empty.
module accumulator_cpu_execute_unit #(
	parameter int MEM_DEPTH  = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // [1:0] kind
	input  logic [47:0] s_tdata,  // [4:0] opcode, [10:5] mem_address, [42:11] write_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata   // [31:0] acc_value, [63:32] temp_value, [95:64] mem_word
);
	import acu_pkg::*;

	localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int ADDR_SPAN = 1 << ADDR_W;

	function automatic int unsigned wrap_addr(input int unsigned a);
		int unsigned v;
		v = a;
		while (v >= MEM_DEPTH) v = v - MEM_DEPTH;
		return v;
	endfunction

	logic [AW-1:0] addr_map [ADDR_SPAN];
	for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_map
		assign addr_map[g] = AW'(wrap_addr(g));
	end

	logic                  in_accept;
	logic [AW-1:0]         in_addr;
	logic [DATA_WIDTH-1:0] in_wv;

	logic                  v_s1;
	logic [KIND_W-1:0]     kind_s1;
	logic [OPC_W-1:0]      op_s1;
	logic [AW-1:0]         addr_s1;
	logic [DATA_WIDTH-1:0] wv_s1;
	logic                  fwd_v_s1;
	logic [DATA_WIDTH-1:0] fwd_d_s1;

	logic [DATA_WIDTH-1:0] ac_q;
	logic [DATA_WIDTH-1:0] tr_q;
	logic                  out_valid_q;
	logic [FIELD_W-1:0]    out_acc_q;
	logic [FIELD_W-1:0]    out_tr_q;
	logic [FIELD_W-1:0]    out_word_q;

	logic [DATA_WIDTH-1:0] mem_rd;
	logic [DATA_WIDTH-1:0] m_s1;
	logic [DATA_WIDTH-1:0] acc_next;
	logic [DATA_WIDTH-1:0] tr_next;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic [DATA_WIDTH-1:0] word_after;
	alu_ctrl_t             ctrl;
	mem_stat_t             stat;
	logic                  fire_s1;
	logic                  wrap_clr_s1;

	assign in_addr = addr_map[s_tdata[10:5]];
	assign in_wv   = DATA_WIDTH'($signed(s_tdata[42:11]));

	assign fire_s1     = v_s1 && (!out_valid_q || m_tready);
	assign wrap_clr_s1 = v_s1 && (kind_s1 == KIND_CLEAR) && stat.epoch_full;
	assign s_tready    = !stat.busy && !wrap_clr_s1 && (!v_s1 || fire_s1);
	assign in_accept   = s_tvalid && s_tready;

	// The memory read for a beat overlaps the write of the beat ahead of it,
	// so that write is captured here and used in place of the stale word.
	assign m_s1 = fwd_v_s1 ? fwd_d_s1 : mem_rd;

	acu_mem #(
		.MEM_DEPTH  (MEM_DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.AW         (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_accept),
		.rd_addr (in_addr),
		.rd_data (mem_rd),
		.wr_en   (fire_s1 && ctrl.mem_we),
		.wr_addr (addr_s1),
		.wr_data (mem_wdata),
		.clr     (fire_s1 && ctrl.clr),
		.stat    (stat)
	);

	acu_alu #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_alu (
		.kind       (kind_s1),
		.opcode     (op_s1),
		.wv         (wv_s1),
		.ac         (ac_q),
		.tr         (tr_q),
		.m          (m_s1),
		.acc_next   (acc_next),
		.tr_next    (tr_next),
		.mem_wdata  (mem_wdata),
		.word_after (word_after),
		.ctrl       (ctrl)
	);

	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1  <= s_tuser;
			op_s1    <= s_tdata[4:0];
			addr_s1  <= in_addr;
			wv_s1    <= in_wv;
			fwd_d_s1 <= ctrl.clr ? '0 : mem_wdata;
		end
		if (fire_s1) begin
			out_acc_q  <= FIELD_W'(acc_next);
			out_tr_q   <= FIELD_W'(tr_next);
			out_word_q <= FIELD_W'(word_after);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			fwd_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			ac_q        <= '0;
			tr_q        <= '0;
		end else begin
			if (in_accept) begin
				v_s1     <= 1'b1;
				fwd_v_s1 <= fire_s1 && (ctrl.clr || (ctrl.mem_we && (addr_s1 == in_addr)));
			end else if (fire_s1) begin
				v_s1 <= 1'b0;
			end
			if (fire_s1) begin
				ac_q        <= acc_next;
				tr_q        <= tr_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_word_q, out_tr_q, out_acc_q};

`ifndef SYNTH
	a_wrap_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && ctrl.clr && stat.epoch_full) |=> stat.busy)
		else $error("wrapping clear did not start a memory sweep");

	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> m_tvalid)
		else $error("executed beat did not reach the output register");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !fire_s1)
		else $error("execute stage active during a memory sweep");

	a_fwd_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && fire_s1 && ctrl.mem_we && (addr_s1 == in_addr)) |=> fwd_v_s1)
		else $error("write to the same word was not forwarded");
`endif

endmodule

// ===== tb/sv/accumulator_cpu_execute_unit_tb.sv =====
`timescale 1ns / 1ps

module accumulator_cpu_execute_unit_tb;
	import acu_pkg::*;

	// Codes the block must ignore: the one spare item kind and the top of the opcode space.
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam logic [OPC_W-1:0]  OP_SPARE   = 5'd31;

	localparam logic [FIELD_W-1:0] MIN_WORD = 32'h8000_0000;
	localparam logic [FIELD_W-1:0] MAX_WORD = 32'h7fff_ffff;
	localparam int NUM_WORDS = 64;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [OPC_W-1:0]   opc;
		logic [ADDR_W-1:0]  adr;
		logic [FIELD_W-1:0] wval;
	} acu_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] acc;
		logic [FIELD_W-1:0] tmp;
		logic [FIELD_W-1:0] mem;
	} acu_state_t;

	typedef struct packed {
		acu_item_t  item;
		logic       known;
		acu_state_t res;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;   // [1:0] kind
	logic [47:0] s_tdata = '0;   // [4:0] opcode, [10:5] mem_address, [42:11] write_value
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;        // [31:0] acc_value, [63:32] temp_value, [95:64] mem_word

	// Shadow copy of the machine state.
	logic [FIELD_W-1:0] mem_shadow [NUM_WORDS];
	logic [FIELD_W-1:0] acc_shadow;
	logic [FIELD_W-1:0] tmp_shadow;

	acu_state_t pending_states [$];
	int unsigned idle_mode = 0;
	int unsigned mismatches = 0;
	int unsigned states_checked = 0;
	int unsigned n_exec = 0, n_write = 0, n_clear = 0, n_spare = 0;
	logic [31:0] ops_seen = '0;

	accumulator_cpu_execute_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// Applies one beat to the shadow state and returns the state the block should report.
	function automatic acu_state_t execute_beat(input acu_item_t it);
		logic [FIELD_W-1:0] ac;
		logic [FIELD_W-1:0] m;
		acu_state_t r;
		ac = acc_shadow;
		m = mem_shadow[it.adr];
		case (it.kind)
			KIND_WRITE: mem_shadow[it.adr] = it.wval;
			KIND_CLEAR: foreach (mem_shadow[k]) mem_shadow[k] = '0;
			KIND_EXEC: begin
				case (it.opc)
					OP_LDA:  ac = m;
					OP_ADD:  ac = ac + m;
					OP_MUL:  ac = ac * m;
					OP_SUB:  ac = ac - m;
					OP_INC:  ac = ac + 1;
					OP_DEC:  ac = ac - 1;
					OP_EXC: begin
						tmp_shadow = ac;
						mem_shadow[it.adr] = ac;
						ac = m;
					end
					OP_OR:   begin tmp_shadow = ac | m;    ac = tmp_shadow; end
					OP_NOT:  begin tmp_shadow = ~m;        ac = tmp_shadow; end
					OP_AND:  begin tmp_shadow = ac & m;    ac = tmp_shadow; end
					OP_XOR:  begin tmp_shadow = ac ^ m;    ac = tmp_shadow; end
					OP_XNOR: begin tmp_shadow = ~(ac ^ m); ac = tmp_shadow; end
					OP_NOR:  begin tmp_shadow = ~(ac | m); ac = tmp_shadow; end
					OP_NAND: begin tmp_shadow = ~(ac & m); ac = tmp_shadow; end
					OP_CLA:  ac = '0;
					OP_CMA:  ac = ~ac;
					OP_TCA:  ac = -ac;
					OP_GTR:  if ($signed(ac) < $signed(m)) ac = m;
					OP_LES:  if ($signed(m) < $signed(ac)) ac = m;
					OP_SHL:  ac = ac << 1;
					OP_SHR:  ac = {ac[FIELD_W-1], ac[FIELD_W-1:1]};
					default: ;
				endcase
				acc_shadow = ac;
			end
			default: ;
		endcase
		r.acc = acc_shadow;
		r.tmp = tmp_shadow;
		r.mem = mem_shadow[it.adr];
		return r;
	endfunction

	function automatic acu_item_t random_item(input int unsigned clear_pct);
		acu_item_t it;
		int unsigned r;
		r = $urandom_range(99);
		if (r < clear_pct)
			it.kind = KIND_CLEAR;
		else if (r < clear_pct + 3)
			it.kind = KIND_SPARE;
		else if (r < clear_pct + 25)
			it.kind = KIND_WRITE;
		else
			it.kind = KIND_EXEC;
		it.opc = ($urandom_range(9) == 0) ? OPC_W'($urandom_range(31, 22))
		                                  : OPC_W'($urandom_range(21));
		// A small pool of addresses keeps written words coming back as operands.
		it.adr = ($urandom_range(9) < 7) ? ADDR_W'($urandom_range(7))
		                                 : ADDR_W'($urandom_range(63));
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(4))
					0: it.wval = MIN_WORD;
					1: it.wval = MAX_WORD;
					2: it.wval = '1;
					3: it.wval = 32'd1;
					default: it.wval = '0;
				endcase
			end
			1: it.wval = FIELD_W'($urandom_range(200)) - 32'd100;
			default: it.wval = $urandom;
		endcase
		return it;
	endfunction

	task automatic send_beat(input acu_item_t it, input logic known, input acu_state_t res);
		int unsigned pct;
		acu_state_t predicted;
		pct = (idle_mode == 0) ? 11 : (idle_mode == 1) ? 54 : 0;
		while ($urandom_range(99) < pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.kind;
		s_tdata <= {5'd0, it.wval, it.adr, it.opc};
		do @(posedge clk); while (!s_tready);
		predicted = execute_beat(it);
		pending_states.push_back(known ? res : predicted);
		case (it.kind)
			KIND_EXEC: begin
				n_exec++;
				ops_seen[it.opc] = 1'b1;
			end
			KIND_WRITE: n_write++;
			KIND_CLEAR: n_clear++;
			default: n_spare++;
		endcase
	endtask

	task automatic check_field(input string fname, input logic [FIELD_W-1:0] expv,
			input logic [FIELD_W-1:0] actv);
		if (expv !== actv) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, fname, expv, actv);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_states.size() == 0) begin
				$display("%0t: unexpected result beat, expected none actual %h", $time, m_tdata);
				mismatches++;
			end else begin
				check_field("acc_value",  pending_states[0].acc, m_tdata[31:0]);
				check_field("temp_value", pending_states[0].tmp, m_tdata[63:32]);
				check_field("mem_word",   pending_states[0].mem, m_tdata[95:64]);
				void'(pending_states.pop_front());
				states_checked++;
			end
		end
	end

	// Result side: random back-pressure, plus one long hold that fills the block up.
	initial begin : result_drain
		int unsigned beats_taken;
		int unsigned hold_left;
		bit held;
		int unsigned pct;
		beats_taken = 0;
		hold_left = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				beats_taken++;
			if (!held && beats_taken >= 60) begin
				held = 1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				pct = (idle_mode == 0) ? 54 : (idle_mode == 1) ? 11 : 0;
				m_tready <= ($urandom_range(99) >= pct);
			end
		end
	end

	initial begin : stimulus
		directed_row_t rows [27];
		rows = '{
			'{'{KIND_EXEC,  OP_LDA,   6'd0,  '0},       1'b1, '{EMPTY_WORD, '0, EMPTY_WORD}},
			'{'{KIND_WRITE, OP_LDA,   6'd63, MIN_WORD}, 1'b1, '{EMPTY_WORD, '0, MIN_WORD}},
			'{'{KIND_EXEC,  OP_LDA,   6'd63, '0},       1'b1, '{MIN_WORD, '0, MIN_WORD}},
			'{'{KIND_EXEC,  OP_DEC,   6'd63, '0},       1'b1, '{MAX_WORD, '0, MIN_WORD}},
			'{'{KIND_EXEC,  OP_INC,   6'd63, '0},       1'b1, '{MIN_WORD, '0, MIN_WORD}},
			'{'{KIND_EXEC,  OP_ADD,   6'd63, '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_SUB,   6'd0,  '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_MUL,   6'd63, '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_EXC,   6'd5,  '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_OR,    6'd63, '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_NOT,   6'd63, '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_AND,   6'd0,  '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_XOR,   6'd5,  '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_XNOR,  6'd63, '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_NOR,   6'd0,  '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_NAND,  6'd63, '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_CLA,   6'd1,  '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_CMA,   6'd1,  '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_TCA,   6'd1,  '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_CIR,   6'd1,  '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_GTR,   6'd63, '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_LES,   6'd0,  '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_SHL,   6'd5,  '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_SHR,   6'd5,  '0},       1'b0, '0},
			'{'{KIND_EXEC,  OP_SPARE, 6'd63, MAX_WORD}, 1'b0, '0},
			'{'{KIND_SPARE, OP_SHR,   6'd63, '1},       1'b0, '0},
			'{'{KIND_CLEAR, OP_LDA,   6'd63, '0},       1'b0, '0}
		};
		foreach (mem_shadow[k]) mem_shadow[k] = EMPTY_WORD;
		acc_shadow = '0;
		tmp_shadow = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		idle_mode = 0;
		foreach (rows[i]) send_beat(rows[i].item, rows[i].known, rows[i].res);
		repeat (100) send_beat(random_item(4), 1'b0, '0);
		idle_mode = 1;
		repeat (100) send_beat(random_item(4), 1'b0, '0);
		// Clear-heavy stretch so the periodic long zeroing sweep gets exercised.
		idle_mode = 2;
		repeat (270) send_beat(random_item(96), 1'b0, '0);
		s_tvalid <= 1'b0;

		while (pending_states.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Checked %0d result beats: %0d executes, %0d writes, %0d clears, %0d spare kinds.",
			states_checked, n_exec, n_write, n_clear, n_spare);
		$display("Opcode map exercised: %b, with three idling regimes and one long output hold.",
			ops_seen);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
